// ----- rtl/fmas_pkg.sv -----
// Shared types, constants and lane-swap helper for the frame memory aperture block.
// No dependencies; imported by every module of the block except fmas_lane_ram.
package fmas_pkg;

  localparam int ADDR_BITS = 23;
  localparam int NUM_LANES = 4;
  localparam int ROW_W     = ADDR_BITS - 2;
  localparam int CFG_AW    = 5;
  localparam int WIN_BITS  = 19;

  localparam logic [1:0] SWAP_BYTE = 2'd1;
  localparam logic [1:0] SWAP_HALF = 2'd2;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  localparam logic [4:0] MIN_LOG2 = 5'd16;
  localparam logic [4:0] MAX_LOG2 = 5'(ADDR_BITS);

  localparam logic [2:0] REG_AP_ONE_SWAP   = 3'd0;
  localparam logic [2:0] REG_AP_ONE_WINDOW = 3'd1;
  localparam logic [2:0] REG_AP_TWO_SWAP   = 3'd2;
  localparam logic [2:0] REG_AP_TWO_WINDOW = 3'd3;
  localparam logic [2:0] REG_HOST_MEM_EN   = 3'd4;
  localparam logic [2:0] REG_BANK_A        = 3'd5;
  localparam logic [2:0] REG_BANK_B        = 3'd6;
  localparam logic [2:0] REG_MEM_SIZE_LOG2 = 3'd7;

  typedef struct packed {
    logic        func;
    logic        aperture;
    logic [22:0] offset;
    logic [1:0]  access_size;
    logic [31:0] write_data;
  } in_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        memory_updated;
  } out_rsp_t;

  typedef struct packed {
    logic [1:0] ap_one_swap;
    logic       ap_one_window;
    logic [1:0] ap_two_swap;
    logic       ap_two_window;
    logic       host_memory_enable;
    logic [2:0] bank_a;
    logic [2:0] bank_b;
    logic [4:0] mem_size_log2;
  } cfg_t;

  typedef struct packed {
    logic             en;
    logic             we;
    logic [ROW_W-1:0] row;
    logic [7:0]       wdata;
  } lane_cmd_t;

  // per-request context carried across the memory read
  typedef struct packed {
    logic       is_write;
    logic       win;
    logic       fill;
    logic       upd;
    logic [1:0] rot;
    logic [2:0] nb;
    logic [1:0] ctl;
  } pend_t;

  function automatic logic [31:0] lane_swap(input logic [1:0] ctl, input logic [2:0] nb,
                                            input logic [31:0] v);
    logic [31:0] r;
    r = v;
    case (ctl)
      SWAP_BYTE: begin
        if (nb == 3'd4) r = {v[7:0], v[15:8], v[23:16], v[31:24]};
        else if (nb == 3'd2) r = {16'h0000, v[7:0], v[15:8]};
      end
      SWAP_HALF: begin
        if (nb == 3'd4) r = {v[15:0], v[31:16]};
      end
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/fmas_cfg_regs.sv -----
// APB-style configuration register file for the aperture block.
// Depends on fmas_pkg (cfg_t, register index codes).
module fmas_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fmas_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output fmas_pkg::cfg_t             cfg
);
  import fmas_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic [2:0] idx;
  logic       wr;

  assign idx = paddr[CFG_AW-1:2];
  assign wr  = psel && penable && pwrite;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_AP_ONE_SWAP:   cfg_nxt.ap_one_swap        = pwdata[1:0];
        REG_AP_ONE_WINDOW: cfg_nxt.ap_one_window      = pwdata[0];
        REG_AP_TWO_SWAP:   cfg_nxt.ap_two_swap        = pwdata[1:0];
        REG_AP_TWO_WINDOW: cfg_nxt.ap_two_window      = pwdata[0];
        REG_HOST_MEM_EN:   cfg_nxt.host_memory_enable = pwdata[0];
        REG_BANK_A:        cfg_nxt.bank_a             = pwdata[2:0];
        REG_BANK_B:        cfg_nxt.bank_b             = pwdata[2:0];
        REG_MEM_SIZE_LOG2: cfg_nxt.mem_size_log2      = pwdata[4:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_AP_ONE_SWAP:   prdata = {30'd0, cfg_r.ap_one_swap};
      REG_AP_ONE_WINDOW: prdata = {31'd0, cfg_r.ap_one_window};
      REG_AP_TWO_SWAP:   prdata = {30'd0, cfg_r.ap_two_swap};
      REG_AP_TWO_WINDOW: prdata = {31'd0, cfg_r.ap_two_window};
      REG_HOST_MEM_EN:   prdata = {31'd0, cfg_r.host_memory_enable};
      REG_BANK_A:        prdata = {29'd0, cfg_r.bank_a};
      REG_BANK_B:        prdata = {29'd0, cfg_r.bank_b};
      REG_MEM_SIZE_LOG2: prdata = {27'd0, cfg_r.mem_size_log2};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r                    <= '0;
      cfg_r.host_memory_enable <= 1'b1;
      cfg_r.mem_size_log2      <= MAX_LOG2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/fmas_lane_ram.sv -----
// One byte lane of frame memory: single port, registered read data.
// Generic; no package dependency.
module fmas_lane_ram #(
  parameter int AW = 21,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (en && we) mem[addr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (en && !we) rdata_r <= mem[addr];
  end

endmodule

// ----- rtl/fmas_access_map.sv -----
// Address translation: swap/window mapping, bounds check and per-lane memory commands.
// Depends on fmas_pkg (request, config, lane command and pending-context types).
module fmas_access_map (
  input  logic                                      go,
  input  fmas_pkg::in_req_t                         req,
  input  fmas_pkg::cfg_t                            cfg,
  output fmas_pkg::lane_cmd_t [fmas_pkg::NUM_LANES-1:0] cmd,
  output fmas_pkg::pend_t                           pend
);
  import fmas_pkg::*;

  logic [2:0]           nb;
  logic [1:0]           ctl;
  logic                 win;
  logic [4:0]           lg;
  logic [ADDR_BITS:0]   memsize;
  logic [ADDR_BITS-1:0] mask;
  logic [ADDR_BITS-1:0] sa;
  logic                 oob;
  logic                 fill;
  logic [1:0]           rot;
  logic [31:0]          wv;
  logic [16:0]          woff;
  logic [2:0]           bank;
  logic [WIN_BITS-1:0]  wa;
  logic [1:0]           bi;
  logic [ADDR_BITS-1:0] byte_addr [NUM_LANES];

  always_comb begin
    case (req.access_size)
      SIZE_BYTE: nb = 3'd1;
      SIZE_HALF: nb = 3'd2;
      default:   nb = 3'd4;
    endcase
    ctl = req.aperture ? cfg.ap_two_swap : cfg.ap_one_swap;
    win = req.aperture ? cfg.ap_two_window : cfg.ap_one_window;

    lg = cfg.mem_size_log2;
    if (lg < MIN_LOG2) lg = MIN_LOG2;
    if (lg > MAX_LOG2) lg = MAX_LOG2;
    memsize = (ADDR_BITS+1)'(1) << lg;
    mask    = ADDR_BITS'(memsize - (ADDR_BITS+1)'(1));

    sa = req.offset;
    case (ctl)
      SWAP_BYTE: begin
        if (nb == 3'd2) sa = req.offset ^ ADDR_BITS'(2);
        else if (nb == 3'd1) sa = req.offset ^ ADDR_BITS'(3);
      end
      SWAP_HALF: begin
        if (nb != 3'd4) sa = req.offset ^ ADDR_BITS'(2);
      end
      default: sa = req.offset;
    endcase

    oob  = ({1'b0, sa} + (ADDR_BITS+1)'(nb)) > memsize;
    fill = win ? !cfg.host_memory_enable : oob;
    rot  = win ? req.offset[1:0] : sa[1:0];
    wv   = win ? req.write_data : lane_swap(ctl, nb, req.write_data);

    for (int i = 0; i < NUM_LANES; i++) begin
      woff = 17'(req.offset[16:0] + 17'(i));
      bank = woff[16] ? cfg.bank_b : cfg.bank_a;
      wa   = {bank, woff[15:0]};
      if (win) byte_addr[i] = ADDR_BITS'(wa) & mask;
      else     byte_addr[i] = ADDR_BITS'(sa + ADDR_BITS'(i)) & mask;
    end

    for (int l = 0; l < NUM_LANES; l++) begin
      bi           = 2'(l) - rot;
      cmd[l].en    = go && ({1'b0, bi} < nb) && !fill;
      cmd[l].we    = req.func;
      cmd[l].row   = byte_addr[bi][ADDR_BITS-1:2];
      cmd[l].wdata = wv[8*bi +: 8];
    end

    pend.is_write = req.func;
    pend.win      = win;
    pend.fill     = fill;
    pend.upd      = req.func && !fill;
    pend.rot      = rot;
    pend.nb       = nb;
    pend.ctl      = ctl;
  end

endmodule

// ----- rtl/frame_memory_aperture_swap.sv -----
// Top level of the frame memory aperture block: config port, four byte-lane memories,
// address map and read-data assembly. Depends on fmas_pkg, fmas_cfg_regs,
// fmas_lane_ram and fmas_access_map.
//
// Usage:
//   A host request (in_data: func, aperture, offset, access_size, write_data) is taken
//   at a clock edge with in_valid high and in_stall low. Each request gives exactly one
//   response on out_data (read_data, memory_updated), handed over when out_valid is
//   high and out_stall is low.
//   Frame memory is four byte-wide lanes of 2^21 entries, one port each; any access of
//   up to four consecutive bytes touches each lane at most once, so writes land at the
//   accept edge and reads are issued there too.
//   Path: the read stage (s1_pend_r, lane read data) feeds the output register.
//   Throughput: one request per cycle unless stalled, set by each lane's single port.
//   A stalled response holds in the output register while one more request may sit
//   in the read stage; beyond that in_stall rises until out_stall drops.
//   Reset (synchronous, rst_n low) empties the pipeline and restores the register
//   defaults; memory contents are not cleared and are defined only once written.
//   Registers are written through psel/penable/pwrite at byte address 4*index.
module frame_memory_aperture_swap (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  fmas_pkg::in_req_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output fmas_pkg::out_rsp_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fmas_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import fmas_pkg::*;

  cfg_t                        cfg;
  lane_cmd_t [NUM_LANES-1:0]   cmd;
  pend_t                       pend;
  logic [NUM_LANES-1:0][7:0]   lane_rd;

  logic     s1_valid_r, s1_valid_nxt;
  pend_t    s1_pend_r;
  logic     out_valid_r, out_valid_nxt;
  out_rsp_t out_data_r;
  out_rsp_t rsp;

  logic        out_can;
  logic        accept;
  logic        s1_move;
  logic [31:0] rb;
  logic [31:0] vmask;
  logic [31:0] v;

  assign pready    = 1'b1;
  assign out_can   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !out_can;
  assign accept    = in_valid && !in_stall;
  assign s1_move   = s1_valid_r && out_can;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  fmas_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  fmas_access_map u_map (
    .go   (accept),
    .req  (in_data),
    .cfg  (cfg),
    .cmd  (cmd),
    .pend (pend)
  );

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    fmas_lane_ram #(
      .AW (ROW_W),
      .DW (8)
    ) u_ram (
      .clk   (clk),
      .en    (cmd[l].en),
      .we    (cmd[l].we),
      .addr  (cmd[l].row),
      .wdata (cmd[l].wdata),
      .rdata (lane_rd[l])
    );
  end

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      rb[8*i +: 8] = lane_rd[2'(s1_pend_r.rot + 2'(i))];
    end
    case (s1_pend_r.nb)
      3'd1:    vmask = 32'h0000_00ff;
      3'd2:    vmask = 32'h0000_ffff;
      default: vmask = 32'hffff_ffff;
    endcase
    v = rb & vmask;
    if (!s1_pend_r.win) v = lane_swap(s1_pend_r.ctl, s1_pend_r.nb, v);
    if (s1_pend_r.fill) v = vmask;
    if (s1_pend_r.is_write) v = 32'd0;
    rsp.read_data      = v;
    rsp.memory_updated = s1_pend_r.upd;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_move) s1_valid_nxt = 1'b0;
    if (accept)  s1_valid_nxt = 1'b1;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (s1_move) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept)  s1_pend_r  <= pend;
    if (s1_move) out_data_r <= rsp;
  end

endmodule
